// ===== rtl/core/rce_pkg.sv =====
// ----------------------------------------------------------------------------
// Ray / cylinder exit distance: shared definitions
// Field widths, register indexes, wall codes and the payload records that
// ride along the root and divide pipelines.
// ----------------------------------------------------------------------------
package rce_pkg;

   // fractional bits of the direction cosines
   localparam int FRAC_BITS_DEF = 16;

   // port field widths
   localparam int POS_W      = 20;
   localparam int DIR_W      = 18;
   localparam int CFG_W      = 20;
   localparam int LEN_W      = 21;
   localparam int WALL_W     = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 24;

   // internal widths fixed by the field ranges
   localparam int DIFF_W = 21;   // plane height minus start z
   localparam int AA_W   = 36;   // dx^2 + dy^2
   localparam int BB_W   = 39;   // px*dx + py*dy
   localparam int CC_W   = 42;   // r^2 - px^2 - py^2
   localparam int MB_W   = 38;   // |bb|
   localparam int MC_W   = 41;   // |cc|
   localparam int DISC_W = 76;   // discriminant
   localparam int ROOT_W = DISC_W / 2;
   localparam int N_W    = 40;   // root - bb
   localparam int NMAG_W = 39;   // |root - bb|
   localparam int DMAG_W = 18;   // |dz|

   // default divider numerator width
   localparam int DIV_NUM_W_DEF = NMAG_W + FRAC_BITS_DEF;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BOTTOM = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TOP    = 2'd2;

   // register reset values
   localparam logic [CFG_W-1:0] RADIUS_RST = 20'd117965;
   localparam logic [CFG_W-1:0] BOTTOM_RST = 20'd0;
   localparam logic [CFG_W-1:0] TOP_RST    = 20'd78643;

   // exit wall codes
   localparam logic [WALL_W-1:0] WALL_TOP    = 2'd0;
   localparam logic [WALL_W-1:0] WALL_SIDE   = 2'd1;
   localparam logic [WALL_W-1:0] WALL_BOTTOM = 2'd2;

   // sideband carried through the square root pipeline
   typedef struct packed {
      logic [AA_W-1:0]          aa;
      logic signed [BB_W-1:0]   bb;
      logic                     vert;
      logic signed [DIR_W-1:0]  dz;
      logic signed [DIFF_W-1:0] diff;
   } sq_pay_type;

   // sideband carried through the side-wall divider
   typedef struct packed {
      logic                     n_neg;
      logic                     vert;
      logic                     dz_pos;
      logic                     dz_neg;
      logic signed [DIFF_W-1:0] diff;
   } dv_pay_type;

endpackage

// ===== rtl/core/rce_sqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit floor square root, one root bit per register stage, with a
// sideband word that travels alongside.
// ----------------------------------------------------------------------------
module rce_sqrt
   import rce_pkg::*;
#(
   parameter int RAD_W = DISC_W,
   parameter int PAY_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [RAD_W-1:0]     in_rad,
   input  logic [PAY_W-1:0]     in_pay,
   output logic                 out_valid,
   output logic [RAD_W/2-1:0]   out_root,
   output logic [PAY_W-1:0]     out_pay
);

   localparam int RT_W   = RAD_W / 2;
   localparam int REM_W  = RT_W + 2;
   localparam int ACC_W  = RT_W + 4;
   localparam int STAGES = RT_W;

   logic             v_ff    [STAGES];
   logic [REM_W-1:0] rem_ff  [STAGES];
   logic [RT_W-1:0]  root_ff [STAGES];
   logic [RAD_W-1:0] rad_ff  [STAGES];
   logic [PAY_W-1:0] pay_ff  [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic             v_src;
      logic [REM_W-1:0] rem_src;
      logic [RT_W-1:0]  root_src;
      logic [RAD_W-1:0] rad_src;
      logic [PAY_W-1:0] pay_src;
      logic [ACC_W-1:0] acc;
      logic [ACC_W-1:0] trial;
      logic             ge;
      logic [REM_W-1:0] rem_in;
      logic [RT_W-1:0]  root_in;
      logic [RAD_W-1:0] rad_in;

      if (k == 0) begin : g_first
         assign v_src    = in_valid;
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = in_rad;
         assign pay_src  = in_pay;
      end else begin : g_next
         assign v_src    = v_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign rad_src  = rad_ff[k-1];
         assign pay_src  = pay_ff[k-1];
      end

      // bring down two radicand bits, try root*4+1
      always_comb begin
         acc     = {rem_src, rad_src[RAD_W-1 -: 2]};
         trial   = ACC_W'({root_src, 2'b01});
         ge      = (acc >= trial);
         rem_in  = ge ? REM_W'(acc - trial) : REM_W'(acc);
         root_in = {root_src[RT_W-2:0], ge};
         rad_in  = {rad_src[RAD_W-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_src;
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_in;
            pay_ff[k]  <= pay_src;
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1];
   assign out_pay   = pay_ff[STAGES-1];

endmodule

// ===== rtl/core/rce_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage. The quotient is
// shifted into the numerator register as the numerator bits are used up.
// ----------------------------------------------------------------------------
module rce_div
   import rce_pkg::*;
#(
   parameter int NUM_W = DIV_NUM_W_DEF,
   parameter int DEN_W = AA_W,
   parameter int PAY_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [PAY_W-1:0] in_pay,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quot,
   output logic [PAY_W-1:0] out_pay
);

   localparam int STAGES = NUM_W;

   logic             v_ff   [STAGES];
   logic [DEN_W-1:0] rem_ff [STAGES];
   logic [NUM_W-1:0] x_ff   [STAGES];
   logic [DEN_W-1:0] den_ff [STAGES];
   logic [PAY_W-1:0] pay_ff [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic             v_src;
      logic [DEN_W-1:0] rem_src;
      logic [NUM_W-1:0] x_src;
      logic [DEN_W-1:0] den_src;
      logic [PAY_W-1:0] pay_src;
      logic [DEN_W:0]   acc;
      logic             ge;
      logic [DEN_W-1:0] rem_in;
      logic [NUM_W-1:0] x_in;

      if (k == 0) begin : g_first
         assign v_src   = in_valid;
         assign rem_src = '0;
         assign x_src   = in_num;
         assign den_src = in_den;
         assign pay_src = in_pay;
      end else begin : g_next
         assign v_src   = v_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign x_src   = x_ff[k-1];
         assign den_src = den_ff[k-1];
         assign pay_src = pay_ff[k-1];
      end

      // shift in next numerator bit, subtract divisor if it fits
      always_comb begin
         acc    = {rem_src, x_src[NUM_W-1]};
         ge     = (acc >= {1'b0, den_src});
         rem_in = ge ? DEN_W'(acc - {1'b0, den_src}) : DEN_W'(acc);
         x_in   = {x_src[NUM_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_src;
         end
         if (en) begin
            rem_ff[k] <= rem_in;
            x_ff[k]   <= x_in;
            den_ff[k] <= den_src;
            pay_ff[k] <= pay_src;
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_quot  = x_ff[STAGES-1];
   assign out_pay   = pay_ff[STAGES-1];

endmodule

// ===== rtl/core/ray_cylinder_exit_distance.sv =====
// ----------------------------------------------------------------------------
// Ray / cylinder exit distance
// Path length from a point inside an upright cylinder to the first wall
// crossed along a direction, and which wall (top, side, bottom).
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one ray per word: start point and direction cosines.
//   rsp_ returns one word per ray, in order: saturated path length and wall.
//   csr_ writes radius, bottom height and top height; write only while no
//   ray is in flight.
// Throughput: one ray per cycle while the output buffer is not full.
// Pipeline: the square root pipeline (one root bit per stage, 38 stages)
//   and the divider pipeline (one quotient bit per stage, 39 + FRAC_BITS
//   stages), plus the product, sum and select stages, lie between
//   acceptance and the output buffer.
// Stall: the whole pipeline advances on one enable. A two-word output
//   buffer sits at the end, so a new ray is accepted while one result waits;
//   req_tready drops only when both buffer entries are full.
// Reset: clears all valid bits and the output buffer, and loads the
//   register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module ray_cylinder_exit_distance
   import rce_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // pos_x[19:0], pos_y[39:20], pos_z[59:40], dir_x[77:60],
   // dir_y[95:78], dir_z[113:96], zero pad [119:114]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // path_length[20:0], wall_hit[22:21], zero pad [23]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CFG_W-1:0]       csr_wdata
);

   localparam int NUM_W = NMAG_W + FRAC_BITS;
   localparam int LS_W  = NUM_W + 1;
   localparam int RES_W = LEN_W + WALL_W;

   logic en;

   // ---------------- configuration registers ----------------
   logic [CFG_W-1:0]        radius_ff;
   logic signed [CFG_W-1:0] bottom_ff;
   logic signed [CFG_W-1:0] top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RST;
         bottom_ff <= BOTTOM_RST;
         top_ff    <= TOP_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_RADIUS: radius_ff <= csr_wdata;
            CSR_BOTTOM: bottom_ff <= csr_wdata;
            CSR_TOP:    top_ff    <= csr_wdata;
            default:    ;
         endcase
      end
   end

   // ---------------- stage 0: input capture ----------------
   logic                    s0_v_ff;
   logic signed [POS_W-1:0] s0_px_ff, s0_py_ff, s0_pz_ff;
   logic signed [DIR_W-1:0] s0_dx_ff, s0_dy_ff, s0_dz_ff;

   // ---------------- stage 1: products ----------------
   logic                     s1_v_ff;
   logic signed [37:0]       s1_pxdx_ff, s1_pydy_ff, s1_pxdx_in, s1_pydy_in;
   logic signed [35:0]       s1_dxdx_ff, s1_dydy_ff, s1_dxdx_in, s1_dydy_in;
   logic signed [39:0]       s1_pxpx_ff, s1_pypy_ff, s1_pxpx_in, s1_pypy_in;
   logic [39:0]              s1_rr_ff, s1_rr_in;
   logic signed [DIR_W-1:0]  s1_dz_ff;
   logic signed [DIFF_W-1:0] s1_diff_ff, s1_diff_in;
   logic signed [CFG_W-1:0]  hsel;

   // ---------------- stage 2: sums ----------------
   logic                     s2_v_ff;
   logic [AA_W-1:0]          s2_aa_ff, s2_aa_in;
   logic signed [BB_W-1:0]   s2_bb_ff, s2_bb_in;
   logic signed [CC_W-1:0]   s2_cc_ff, s2_cc_in;
   logic                     s2_vert_ff, s2_vert_in;
   logic signed [DIR_W-1:0]  s2_dz_ff;
   logic signed [DIFF_W-1:0] s2_diff_ff;

   // ---------------- stage 3: magnitudes ----------------
   logic                     s3_v_ff;
   logic [MB_W-1:0]          s3_mb_ff, s3_mb_in;
   logic [MC_W-1:0]          s3_mc_ff, s3_mc_in;
   logic                     s3_cneg_ff;
   logic [AA_W-1:0]          s3_aa_ff;
   logic signed [BB_W-1:0]   s3_bb_ff;
   logic                     s3_vert_ff;
   logic signed [DIR_W-1:0]  s3_dz_ff;
   logic signed [DIFF_W-1:0] s3_diff_ff;

   // ---------------- stage 4: partial products ----------------
   logic                     s4_v_ff;
   logic [37:0]              s4_phh_ff, s4_phl_ff, s4_pll_ff;
   logic [38:0]              s4_qhh_ff, s4_qlh_ff;
   logic [37:0]              s4_qhl_ff, s4_qll_ff;
   logic                     s4_cneg_ff;
   logic [AA_W-1:0]          s4_aa_ff;
   logic signed [BB_W-1:0]   s4_bb_ff;
   logic                     s4_vert_ff;
   logic signed [DIR_W-1:0]  s4_dz_ff;
   logic signed [DIFF_W-1:0] s4_diff_ff;

   // ---------------- stage 5: b^2 and a*|c| ----------------
   logic                     s5_v_ff;
   logic [DISC_W-1:0]        s5_bsq_ff, s5_ac_ff, s5_bsq_in, s5_ac_in;
   logic                     s5_cneg_ff;
   logic [AA_W-1:0]          s5_aa_ff;
   logic signed [BB_W-1:0]   s5_bb_ff;
   logic                     s5_vert_ff;
   logic signed [DIR_W-1:0]  s5_dz_ff;
   logic signed [DIFF_W-1:0] s5_diff_ff;

   // ---------------- stage 6: discriminant ----------------
   logic                     s6_v_ff;
   logic [DISC_W-1:0]        s6_disc_ff, s6_disc_in;
   sq_pay_type               s6_pay_ff;

   always_comb begin
      // products
      hsel       = (!s0_dz_ff[DIR_W-1] && (s0_dz_ff != '0)) ? top_ff : bottom_ff;
      s1_pxdx_in = s0_px_ff * s0_dx_ff;
      s1_pydy_in = s0_py_ff * s0_dy_ff;
      s1_dxdx_in = s0_dx_ff * s0_dx_ff;
      s1_dydy_in = s0_dy_ff * s0_dy_ff;
      s1_pxpx_in = s0_px_ff * s0_px_ff;
      s1_pypy_in = s0_py_ff * s0_py_ff;
      s1_rr_in   = 40'(radius_ff) * 40'(radius_ff);
      s1_diff_in = DIFF_W'(hsel) - DIFF_W'(s0_pz_ff);
      // sums
      s2_aa_in   = AA_W'(s1_dxdx_ff[34:0]) + AA_W'(s1_dydy_ff[34:0]);
      s2_bb_in   = BB_W'(s1_pxdx_ff) + BB_W'(s1_pydy_ff);
      s2_cc_in   = $signed({2'b00, s1_rr_ff}) - CC_W'(s1_pxpx_ff) - CC_W'(s1_pypy_ff);
      s2_vert_in = (s1_dxdx_ff == '0) && (s1_dydy_ff == '0);
      // magnitudes
      s3_mb_in   = s2_bb_ff[BB_W-1] ? MB_W'(-s2_bb_ff) : MB_W'(s2_bb_ff);
      s3_mc_in   = s2_cc_ff[CC_W-1] ? MC_W'(-s2_cc_ff) : MC_W'(s2_cc_ff);
      // recombine partial products
      s5_bsq_in  = (DISC_W'(s4_phh_ff) << 38) + (DISC_W'(s4_phl_ff) << 20)
                 + DISC_W'(s4_pll_ff);
      s5_ac_in   = (DISC_W'(s4_qhh_ff) << 38) + (DISC_W'(s4_qhl_ff) << 18)
                 + (DISC_W'(s4_qlh_ff) << 20) + DISC_W'(s4_qll_ff);
      // negative c: subtract, clamp to zero on a miss
      if (!s5_cneg_ff) begin
         s6_disc_in = s5_bsq_ff + s5_ac_ff;
      end else if (s5_bsq_ff < s5_ac_ff) begin
         s6_disc_in = '0;
      end else begin
         s6_disc_in = s5_bsq_ff - s5_ac_ff;
      end
   end

   // front valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
      end else if (en) begin
         s0_v_ff <= req_tvalid;
         s1_v_ff <= s0_v_ff;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
         s6_v_ff <= s5_v_ff;
      end
   end

   // front data path
   always_ff @(posedge clock) begin
      if (en) begin
         s0_px_ff   <= req_tdata[19:0];
         s0_py_ff   <= req_tdata[39:20];
         s0_pz_ff   <= req_tdata[59:40];
         s0_dx_ff   <= req_tdata[77:60];
         s0_dy_ff   <= req_tdata[95:78];
         s0_dz_ff   <= req_tdata[113:96];

         s1_pxdx_ff <= s1_pxdx_in;
         s1_pydy_ff <= s1_pydy_in;
         s1_dxdx_ff <= s1_dxdx_in;
         s1_dydy_ff <= s1_dydy_in;
         s1_pxpx_ff <= s1_pxpx_in;
         s1_pypy_ff <= s1_pypy_in;
         s1_rr_ff   <= s1_rr_in;
         s1_dz_ff   <= s0_dz_ff;
         s1_diff_ff <= s1_diff_in;

         s2_aa_ff   <= s2_aa_in;
         s2_bb_ff   <= s2_bb_in;
         s2_cc_ff   <= s2_cc_in;
         s2_vert_ff <= s2_vert_in;
         s2_dz_ff   <= s1_dz_ff;
         s2_diff_ff <= s1_diff_ff;

         s3_mb_ff   <= s3_mb_in;
         s3_mc_ff   <= s3_mc_in;
         s3_cneg_ff <= s2_cc_ff[CC_W-1];
         s3_aa_ff   <= s2_aa_ff;
         s3_bb_ff   <= s2_bb_ff;
         s3_vert_ff <= s2_vert_ff;
         s3_dz_ff   <= s2_dz_ff;
         s3_diff_ff <= s2_diff_ff;

         s4_phh_ff  <= s3_mb_ff[37:19] * s3_mb_ff[37:19];
         s4_phl_ff  <= s3_mb_ff[37:19] * s3_mb_ff[18:0];
         s4_pll_ff  <= s3_mb_ff[18:0]  * s3_mb_ff[18:0];
         s4_qhh_ff  <= s3_aa_ff[35:18] * s3_mc_ff[40:20];
         s4_qhl_ff  <= s3_aa_ff[35:18] * s3_mc_ff[19:0];
         s4_qlh_ff  <= s3_aa_ff[17:0]  * s3_mc_ff[40:20];
         s4_qll_ff  <= s3_aa_ff[17:0]  * s3_mc_ff[19:0];
         s4_cneg_ff <= s3_cneg_ff;
         s4_aa_ff   <= s3_aa_ff;
         s4_bb_ff   <= s3_bb_ff;
         s4_vert_ff <= s3_vert_ff;
         s4_dz_ff   <= s3_dz_ff;
         s4_diff_ff <= s3_diff_ff;

         s5_bsq_ff  <= s5_bsq_in;
         s5_ac_ff   <= s5_ac_in;
         s5_cneg_ff <= s4_cneg_ff;
         s5_aa_ff   <= s4_aa_ff;
         s5_bb_ff   <= s4_bb_ff;
         s5_vert_ff <= s4_vert_ff;
         s5_dz_ff   <= s4_dz_ff;
         s5_diff_ff <= s4_diff_ff;

         s6_disc_ff     <= s6_disc_in;
         s6_pay_ff.aa   <= s5_aa_ff;
         s6_pay_ff.bb   <= s5_bb_ff;
         s6_pay_ff.vert <= s5_vert_ff;
         s6_pay_ff.dz   <= s5_dz_ff;
         s6_pay_ff.diff <= s5_diff_ff;
      end
   end

   // ---------------- square root ----------------
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   sq_pay_type        sq_pay;

   rce_sqrt #(
      .RAD_W (DISC_W),
      .PAY_W ($bits(sq_pay_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s6_v_ff),
      .in_rad    (s6_disc_ff),
      .in_pay    (s6_pay_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_pay   (sq_pay)
   );

   // ---------------- stage 7: root - b, plane operands ----------------
   logic                     s7_v_ff;
   logic signed [N_W-1:0]    s7_n_ff, s7_n_in;
   logic [DIFF_W-1:0]        s7_pnum_ff, s7_pnum_in;
   logic [DMAG_W-1:0]        s7_dmag_ff, s7_dmag_in;
   logic                     s7_tneg_ff;
   logic [AA_W-1:0]          s7_aa_ff;
   logic                     s7_vert_ff, s7_dzpos_ff, s7_dzneg_ff;
   logic signed [DIFF_W-1:0] s7_diff_ff;

   // ---------------- stage 8: |n| ----------------
   logic                     s8_v_ff;
   logic [NMAG_W-1:0]        s8_nmag_ff, s8_nmag_in;
   logic [DIFF_W-1:0]        s8_pnum_ff;
   logic [DMAG_W-1:0]        s8_dmag_ff;
   logic                     s8_tneg_ff;
   logic [AA_W-1:0]          s8_aa_ff;
   dv_pay_type               s8_pay_ff;

   always_comb begin
      s7_n_in    = $signed({2'b00, sq_root}) - N_W'(sq_pay.bb);
      s7_pnum_in = sq_pay.diff[DIFF_W-1] ? DIFF_W'(-sq_pay.diff) : DIFF_W'(sq_pay.diff);
      s7_dmag_in = sq_pay.dz[DIR_W-1] ? DMAG_W'(-sq_pay.dz) : DMAG_W'(sq_pay.dz);
      s8_nmag_in = s7_n_ff[N_W-1] ? NMAG_W'(-s7_n_ff) : NMAG_W'(s7_n_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_v_ff <= 1'b0;
         s8_v_ff <= 1'b0;
      end else if (en) begin
         s7_v_ff <= sq_valid;
         s8_v_ff <= s7_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_n_ff     <= s7_n_in;
         s7_pnum_ff  <= s7_pnum_in;
         s7_dmag_ff  <= s7_dmag_in;
         s7_tneg_ff  <= sq_pay.diff[DIFF_W-1] ^ sq_pay.dz[DIR_W-1];
         s7_aa_ff    <= sq_pay.aa;
         s7_vert_ff  <= sq_pay.vert;
         s7_dzpos_ff <= !sq_pay.dz[DIR_W-1] && (sq_pay.dz != '0);
         s7_dzneg_ff <= sq_pay.dz[DIR_W-1];
         s7_diff_ff  <= sq_pay.diff;

         s8_nmag_ff       <= s8_nmag_in;
         s8_pnum_ff       <= s7_pnum_ff;
         s8_dmag_ff       <= s7_dmag_ff;
         s8_tneg_ff       <= s7_tneg_ff;
         s8_aa_ff         <= s7_aa_ff;
         s8_pay_ff.n_neg  <= s7_n_ff[N_W-1];
         s8_pay_ff.vert   <= s7_vert_ff;
         s8_pay_ff.dz_pos <= s7_dzpos_ff;
         s8_pay_ff.dz_neg <= s7_dzneg_ff;
         s8_pay_ff.diff   <= s7_diff_ff;
      end
   end

   // ---------------- dividers: side and plane ----------------
   logic             sd_valid, pd_valid;
   logic [NUM_W-1:0] sd_quot, pd_quot;
   dv_pay_type       sd_pay;
   logic             pd_tneg;

   rce_div #(
      .NUM_W (NUM_W),
      .DEN_W (AA_W),
      .PAY_W ($bits(dv_pay_type))
   ) u_side_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s8_v_ff),
      .in_num    ({s8_nmag_ff, {FRAC_BITS{1'b0}}}),
      .in_den    (s8_aa_ff),
      .in_pay    (s8_pay_ff),
      .out_valid (sd_valid),
      .out_quot  (sd_quot),
      .out_pay   (sd_pay)
   );

   rce_div #(
      .NUM_W (NUM_W),
      .DEN_W (DMAG_W),
      .PAY_W (1)
   ) u_plane_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s8_v_ff),
      .in_num    (NUM_W'({s8_pnum_ff, {FRAC_BITS{1'b0}}})),
      .in_den    (s8_dmag_ff),
      .in_pay    (s8_tneg_ff),
      .out_valid (pd_valid),
      .out_quot  (pd_quot),
      .out_pay   (pd_tneg)
   );

   // ---------------- stage 9: signed lengths ----------------
   logic                    s9_v_ff;
   logic signed [LS_W-1:0]  s9_side_ff, s9_side_in, s9_plane_ff, s9_plane_in;
   logic signed [DIFF_W:0]  s9_vlen_ff, s9_vlen_in;
   logic                    s9_vert_ff, s9_dzpos_ff, s9_dzneg_ff;

   // ---------------- stage 10: wall select ----------------
   logic                    s10_v_ff;
   logic signed [LS_W-1:0]  s10_len_ff, s10_len_in;
   logic [WALL_W-1:0]       s10_wall_ff, s10_wall_in;

   // ---------------- stage 11: saturation ----------------
   logic                    s11_v_ff;
   logic [LEN_W-1:0]        s11_len_ff, s11_len_in;
   logic [WALL_W-1:0]       s11_wall_ff;
   logic                    sat_hi, sat_lo;

   always_comb begin
      s9_side_in  = sd_pay.n_neg ? -$signed({1'b0, sd_quot}) : $signed({1'b0, sd_quot});
      s9_plane_in = pd_tneg ? -$signed({1'b0, pd_quot}) : $signed({1'b0, pd_quot});
      s9_vlen_in  = sd_pay.dz_pos ? (DIFF_W+1)'(sd_pay.diff) : -(DIFF_W+1)'(sd_pay.diff);

      // a vertical ray takes the plane; else plane wins only when strictly closer than the side wall
      if (s9_vert_ff) begin
         s10_len_in  = LS_W'(s9_vlen_ff);
         s10_wall_in = s9_dzpos_ff ? WALL_TOP : WALL_BOTTOM;
      end else if (s9_dzneg_ff && (s9_side_ff > s9_plane_ff)) begin
         s10_len_in  = s9_plane_ff;
         s10_wall_in = WALL_BOTTOM;
      end else if (s9_dzpos_ff && (s9_side_ff > s9_plane_ff)) begin
         s10_len_in  = s9_plane_ff;
         s10_wall_in = WALL_TOP;
      end else begin
         s10_len_in  = s9_side_ff;
         s10_wall_in = WALL_SIDE;
      end

      sat_hi = !s10_len_ff[LS_W-1] && (|s10_len_ff[LS_W-2:LEN_W-1]);
      sat_lo = s10_len_ff[LS_W-1] && !(&s10_len_ff[LS_W-2:LEN_W-1]);
      if (sat_hi) begin
         s11_len_in = {1'b0, {(LEN_W-1){1'b1}}};
      end else if (sat_lo) begin
         s11_len_in = {1'b1, {(LEN_W-1){1'b0}}};
      end else begin
         s11_len_in = s10_len_ff[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_v_ff  <= 1'b0;
         s10_v_ff <= 1'b0;
         s11_v_ff <= 1'b0;
      end else if (en) begin
         s9_v_ff  <= sd_valid && pd_valid;
         s10_v_ff <= s9_v_ff;
         s11_v_ff <= s10_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s9_side_ff  <= s9_side_in;
         s9_plane_ff <= s9_plane_in;
         s9_vlen_ff  <= s9_vlen_in;
         s9_vert_ff  <= sd_pay.vert;
         s9_dzpos_ff <= sd_pay.dz_pos;
         s9_dzneg_ff <= sd_pay.dz_neg;
         s10_len_ff  <= s10_len_in;
         s10_wall_ff <= s10_wall_in;
         s11_len_ff  <= s11_len_in;
         s11_wall_ff <= s10_wall_ff;
      end
   end

   // ---------------- two-word output buffer ----------------
   logic [RES_W-1:0] fifo_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;

   assign en         = (cnt_ff != 2'd2);
   assign req_tready = en;
   assign push       = en && s11_v_ff;
   assign pop        = rsp_tvalid && rsp_tready;

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= {s11_wall_ff, s11_len_ff};
      end
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {1'b0, fifo_ff[rd_ptr_ff]};

endmodule

// ===== rtl/core/rce_checker.sv =====
// ----------------------------------------------------------------------------
// Ray / cylinder exit distance: port checker
// Watches the top level's ports and flags illegal result words and
// handshake slips. Attached to the top level by the bind below.
// ----------------------------------------------------------------------------
module rce_checker
   import rce_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result word holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // wall code is always a real wall
   a_wall_code : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[22:21] == WALL_TOP) || (rsp_tdata[22:21] == WALL_SIDE)
                     || (rsp_tdata[22:21] == WALL_BOTTOM))
      else $error("illegal wall code");

   // pad bit stays zero
   a_pad_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[RSP_DATA_W-1])
      else $error("result pad bit set");

   // an empty output buffer never back-pressures the input
   a_ready_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // nothing comes out right after reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word after reset");

endmodule

bind ray_cylinder_exit_distance rce_checker u_rce_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
